// ----- design/ufsc_pkg.sv -----
// shared constants, types and helpers for the union-find set counter
package ufsc_pkg;

    // element store geometry
    localparam int IDX_W         = 10;
    localparam int ELEMENT_COUNT = 1 << IDX_W;
    localparam int SIZE_W        = IDX_W + 1;
    localparam int EXTRA_W       = 32;

    // stream payload widths
    localparam int OP_W     = 2;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 56;

    // operation codes (the unused code behaves as a query)
    localparam logic [OP_W-1:0] OP_QUERY = 2'd0;
    localparam logic [OP_W-1:0] OP_MERGE = 2'd1;
    localparam logic [OP_W-1:0] OP_INC   = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND_A,
        ST_FIND_B,
        ST_READ_A,
        ST_READ_B,
        ST_UPDATE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_wr;
        logic load_in;
        logic walk;
        logic a_found;
        logic b_found;
        logic sel_b;
        logic cap_a;
        logic update;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic root_hit;
        logic out_free;
    } status_t;

    // saturating counter sum
    function automatic logic [EXTRA_W-1:0] sat_add(input logic [EXTRA_W-1:0] x,
                                                   input logic [EXTRA_W-1:0] y);
        logic [EXTRA_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[EXTRA_W] ? {EXTRA_W{1'b1}} : s[EXTRA_W-1:0];
    endfunction

endpackage

// ----- design/ufsc_ctrl.sv -----
// sequencing state machine for the union-find set counter
module ufsc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ufsc_pkg::status_t status,
    output ufsc_pkg::cmd_t    cmd
);
    import ufsc_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_FIND_A;
                end
            end
            ST_FIND_A:
            begin
                if (status.root_hit)
                begin
                    cmd.a_found = 1'b1;
                    state_next  = ST_FIND_B;
                end
                else
                begin
                    cmd.walk = 1'b1;
                end
            end
            ST_FIND_B:
            begin
                if (status.root_hit)
                begin
                    cmd.b_found = 1'b1;
                    state_next  = ST_READ_A;
                end
                else
                begin
                    cmd.walk = 1'b1;
                end
            end
            ST_READ_A:
            begin
                state_next = ST_READ_B;
            end
            ST_READ_B:
            begin
                cmd.sel_b  = 1'b1;
                cmd.cap_a  = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.sel_b = 1'b1;
                if (status.out_free)
                begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ----- design/ufsc_datapath.sv -----
// element memories, root walker, merge and counter update, result register
module ufsc_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ufsc_pkg::cmd_t                cmd,
    output ufsc_pkg::status_t             status,
    input  logic [ufsc_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ufsc_pkg::M_DATA_W-1:0] m_tdata
);
    import ufsc_pkg::*;

    // element stores
    logic [IDX_W-1:0]   parent_mem [ELEMENT_COUNT];
    logic [SIZE_W-1:0]  size_mem   [ELEMENT_COUNT];
    logic [EXTRA_W-1:0] extra_mem  [ELEMENT_COUNT];

    logic [IDX_W-1:0]   clr_cnt_reg;
    logic [OP_W-1:0]    op_reg;
    logic [IDX_W-1:0]   b_idx_reg;
    logic [IDX_W-1:0]   cursor_reg;
    logic [IDX_W-1:0]   cursor_next;
    logic [IDX_W-1:0]   par_q_reg;
    logic [IDX_W-1:0]   ra_reg;
    logic [IDX_W-1:0]   rb_reg;
    logic [SIZE_W-1:0]  size_q_reg;
    logic [EXTRA_W-1:0] extra_q_reg;
    logic [SIZE_W-1:0]  size_a_reg;
    logic [EXTRA_W-1:0] extra_a_reg;
    logic [IDX_W-1:0]   rd_addr;

    logic               out_valid_reg;
    logic [IDX_W-1:0]   out_ra_reg;
    logic [IDX_W-1:0]   out_rb_reg;
    logic               out_same_reg;
    logic [EXTRA_W-1:0] out_extra_reg;
    logic               out_merged_reg;

    logic               is_merge;
    logic               is_inc;
    logic               a_wins;
    logic [IDX_W-1:0]   win_idx;
    logic [IDX_W-1:0]   lose_idx;
    logic [EXTRA_W-1:0] merge_extra;
    logic [EXTRA_W-1:0] inc_extra;

    logic               par_we;
    logic [IDX_W-1:0]   par_waddr;
    logic [IDX_W-1:0]   par_wdata;
    logic               size_we;
    logic [IDX_W-1:0]   size_waddr;
    logic [SIZE_W-1:0]  size_wdata;
    logic               extra_we;
    logic [IDX_W-1:0]   extra_waddr;
    logic [EXTRA_W-1:0] extra_wdata;

    // clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // walk cursor: the parent read always tracks the next cursor
    always_comb
    begin
        priority if (cmd.load_in)
        begin
            cursor_next = s_tdata[OP_W +: IDX_W];
        end
        else if (cmd.a_found)
        begin
            cursor_next = b_idx_reg;
        end
        else if (cmd.walk)
        begin
            cursor_next = par_q_reg;
        end
        else
        begin
            cursor_next = cursor_reg;
        end
    end

    // input latch, cursor and found roots
    always_ff @(posedge clk)
    begin
        cursor_reg <= cursor_next;
        if (cmd.load_in)
        begin
            op_reg    <= s_tdata[0 +: OP_W];
            b_idx_reg <= s_tdata[OP_W + IDX_W +: IDX_W];
        end
        if (cmd.a_found)
        begin
            ra_reg <= cursor_reg;
        end
        if (cmd.b_found)
        begin
            rb_reg <= cursor_reg;
        end
        if (cmd.cap_a)
        begin
            size_a_reg  <= size_q_reg;
            extra_a_reg <= extra_q_reg;
        end
    end

    assign rd_addr = cmd.sel_b ? rb_reg : ra_reg;

    // update decisions
    assign is_merge    = (op_reg == OP_MERGE) && (ra_reg != rb_reg);
    assign is_inc      = (op_reg == OP_INC);
    assign a_wins      = !(size_a_reg < size_q_reg);
    assign win_idx     = a_wins ? ra_reg : rb_reg;
    assign lose_idx    = a_wins ? rb_reg : ra_reg;
    assign merge_extra = sat_add(extra_a_reg, extra_q_reg);
    assign inc_extra   = sat_add(extra_a_reg, EXTRA_W'(1));

    // memory write selection
    always_comb
    begin
        par_we      = 1'b0;
        par_waddr   = clr_cnt_reg;
        par_wdata   = clr_cnt_reg;
        size_we     = 1'b0;
        size_waddr  = clr_cnt_reg;
        size_wdata  = SIZE_W'(1);
        extra_we    = 1'b0;
        extra_waddr = clr_cnt_reg;
        extra_wdata = '0;
        if (cmd.clear_wr)
        begin
            par_we   = 1'b1;
            size_we  = 1'b1;
            extra_we = 1'b1;
        end
        else if (cmd.update && is_merge)
        begin
            par_we      = 1'b1;
            par_waddr   = lose_idx;
            par_wdata   = win_idx;
            size_we     = 1'b1;
            size_waddr  = win_idx;
            size_wdata  = size_a_reg + size_q_reg;
            extra_we    = 1'b1;
            extra_waddr = win_idx;
            extra_wdata = merge_extra;
        end
        else if (cmd.update && is_inc)
        begin
            extra_we    = 1'b1;
            extra_waddr = ra_reg;
            extra_wdata = inc_extra;
        end
    end

    // parent store
    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            parent_mem[par_waddr] <= par_wdata;
        end
        par_q_reg <= parent_mem[cursor_next];
    end

    // size store
    always_ff @(posedge clk)
    begin
        if (size_we)
        begin
            size_mem[size_waddr] <= size_wdata;
        end
        size_q_reg <= size_mem[rd_addr];
    end

    // counter store
    always_ff @(posedge clk)
    begin
        if (extra_we)
        begin
            extra_mem[extra_waddr] <= extra_wdata;
        end
        extra_q_reg <= extra_mem[rd_addr];
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            out_ra_reg     <= is_merge ? win_idx : ra_reg;
            out_rb_reg     <= is_merge ? win_idx : rb_reg;
            out_same_reg   <= is_merge || (ra_reg == rb_reg);
            out_merged_reg <= is_merge;
            priority if (is_merge)
            begin
                out_extra_reg <= merge_extra;
            end
            else if (is_inc)
            begin
                out_extra_reg <= inc_extra;
            end
            else
            begin
                out_extra_reg <= extra_a_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_merged_reg, out_extra_reg, out_same_reg,
                       out_rb_reg, out_ra_reg};

    // status back to the controller
    assign status.clear_last = (clr_cnt_reg == IDX_W'(ELEMENT_COUNT - 1));
    assign status.root_hit   = (par_q_reg == cursor_reg);
    assign status.out_free   = !out_valid_reg || m_tready;

endmodule

// ----- design/union_find_with_set_counter.sv -----
// top level of the disjoint-set store with per-set event counters
//
//  channel   dir  fields (low bit first)
//  s_axis    in   opcode[1:0] first_index[11:2] second_index[21:12] zero pad[23:22]
//  m_axis    out  first_root[9:0] second_root[19:10] same_set[20]
//                 first_extra[52:21] merged[53] zero pad[55:54]
//
// one item at a time: the item is accepted in ST_IDLE, each of the two finds walks
// parent links up to its root (set depth d <= 10), then ST_READ_A, ST_READ_B and
// ST_UPDATE do the size/counter reads and the update
// after reset a clearing pass writes all 1024 entries, with s_tready low
// a stalled result is held in the output register; the update waits for it to drain
module union_find_with_set_counter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // opcode, first_index, second_index
    input  logic [ufsc_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // first_root, second_root, same_set, first_extra, merged
    output logic [ufsc_pkg::M_DATA_W-1:0] m_tdata
);
    import ufsc_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencing
    ufsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // storage and arithmetic
    ufsc_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- design/ufsc_checker.sv -----
// port-level assertions for the union-find set counter, bound to the top level
module ufsc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ufsc_pkg::M_DATA_W-1:0] m_tdata
);
    import ufsc_pkg::*;

    // a stalled result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item in flight: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // same_set agrees with the reported roots
    a_same_set: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[20] == (m_tdata[9:0] == m_tdata[19:10])))
        else $error("same_set disagrees with roots");

    // a merge always leaves both elements in one set
    a_merged_same: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[53] |-> m_tdata[20])
        else $error("merged result without shared set");

    // padding bits stay clear
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[55:54] == 2'b00))
        else $error("result padding not zero");

endmodule

bind union_find_with_set_counter ufsc_checker u_ufsc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
